>>> sv/astar_pkg.sv
// Shared constants, codes, types and helpers for the A* path search block.
`timescale 1ns / 1ps

package astar_pkg;

	localparam int NODES      = 256;
	localparam int NODE_W     = 8;
	localparam int MAX_DEGREE = 8;
	localparam int SLOT_W     = 3;
	localparam int NB_AW      = NODE_W + SLOT_W;
	localparam int OPEN_DEPTH = 1024;
	localparam int HEAP_AW    = 10;
	localparam int HEAP_CW    = HEAP_AW + 1;
	localparam int MAX_PATH   = 64;
	localparam int PATH_AW    = 6;
	localparam int PATH_LW    = PATH_AW + 1;
	localparam int COORD_W    = 16;
	localparam int SCORE_W    = 24;
	localparam int DIST_W     = 17;
	localparam int SQ_W       = 2 * (COORD_W + 1);
	localparam int KEY_W      = SCORE_W + NODE_W;
	localparam int CNT_W      = 9;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	localparam logic [1:0] MODE_COORD = 2'd0;
	localparam logic [1:0] MODE_NBR   = 2'd1;
	localparam logic [1:0] MODE_BLOCK = 2'd2;
	localparam logic [1:0] MODE_FIND  = 2'd3;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_NO_PATH   = 3'd1;
	localparam logic [2:0] STATUS_OVERFLOW  = 3'd2;
	localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
	localparam logic [2:0] STATUS_BAD_INDEX = 3'd4;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic             clear;
		logic [KEY_W-1:0] key;
	} heap_req_t;

	typedef struct packed {
		logic             done;
		logic             full;
		logic             empty;
		logic [KEY_W-1:0] top;
	} heap_rsp_t;

	function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
		input logic [SCORE_W-1:0] b);
		logic [SCORE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
	endfunction

endpackage

>>> sv/astar_path_search.sv
// Top level of the A* path search block: graph stores, search sequencer, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Contents
// in        request    in_valid / in_ready   mode, node, slot, neighbour, coordinates, ends
// out       result     out_valid / out_ready path_node, last, status, path_cost
// cfg       request    cfg_valid / cfg_ready node_count write data
//
// After reset a clearing pass over every neighbour-table address empties the neighbour
// table, the coordinates and the blocked flags; no request is taken until it ends.
// A load request leaves one acknowledgement in the result register.
// A find request computes each distance in the shared squarer and square-root unit,
// and each heap push or pop moves its key one level at a time.
// The block accepts the next request only after every result of the current one is taken.

module astar_path_search import astar_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic [NODE_W-1:0]         node,
	input  logic [SLOT_W-1:0]         slot,
	input  logic [NODE_W-1:0]         neighbour,
	input  logic                      neighbour_present,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic                      blocked_flag,
	input  logic [NODE_W-1:0]         start_node,
	input  logic [NODE_W-1:0]         goal_node,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [NODE_W-1:0]         path_node,
	output logic                      last,
	output logic [2:0]                status,
	output logic [SCORE_W-1:0]        path_cost,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CNT_W-1:0]          cfg_data
);

	localparam logic [4:0] ST_CLR   = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_FIND  = 5'd2;
	localparam logic [4:0] ST_DRD   = 5'd3;
	localparam logic [4:0] ST_DGO   = 5'd4;
	localparam logic [4:0] ST_DWAIT = 5'd5;
	localparam logic [4:0] ST_H     = 5'd6;
	localparam logic [4:0] ST_PUSHW = 5'd7;
	localparam logic [4:0] ST_NEXT  = 5'd8;
	localparam logic [4:0] ST_LOOP  = 5'd9;
	localparam logic [4:0] ST_POPW  = 5'd10;
	localparam logic [4:0] ST_EST   = 5'd11;
	localparam logic [4:0] ST_CHK   = 5'd12;
	localparam logic [4:0] ST_NBRD  = 5'd13;
	localparam logic [4:0] ST_NB    = 5'd14;
	localparam logic [4:0] ST_BLK   = 5'd15;
	localparam logic [4:0] ST_T     = 5'd16;
	localparam logic [4:0] ST_PATH  = 5'd17;
	localparam logic [4:0] ST_PAR   = 5'd18;
	localparam logic [4:0] ST_ORD   = 5'd19;
	localparam logic [4:0] ST_OUT   = 5'd20;
	localparam logic [4:0] ST_OWAIT = 5'd21;

	// Graph stores, cleared by the pass after reset.
	logic signed [COORD_W-1:0] cx_mem [NODES];
	logic signed [COORD_W-1:0] cy_mem [NODES];
	logic [NODE_W:0]           nb_mem [NODES*MAX_DEGREE];
	logic                      blk_mem [NODES];
	// Per-search stores, guarded by the valid vectors below.
	logic [SCORE_W-1:0]        cost_mem [NODES];
	logic [SCORE_W-1:0]        est_mem [NODES];
	logic [NODE_W-1:0]         par_mem [NODES];
	logic [NODE_W-1:0]         pb_mem [MAX_PATH];

	logic [4:0]          state_q, ret_q;
	logic [NB_AW-1:0]    clr_q;
	logic [CNT_W-1:0]    node_count_q, cnt;
	logic [NODE_W-1:0]   start_q, goal_q, n_q, m_q, c_q, dist_a_q, dist_b_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SCORE_W-1:0]  cost_n_q, costm_q, t_q, cost_goal_q, key_f_q;
	logic [DIST_W-1:0]   d_q;
	logic [PATH_LW-1:0]  len_q, k_q;
	logic                more_q;
	logic [NODES-1:0]    cvalid_q, pvalid_q;

	logic                out_valid_q, last_q;
	logic [NODE_W-1:0]   path_node_q;
	logic [2:0]          status_q;
	logic [SCORE_W-1:0]  path_cost_q;

	logic signed [COORD_W-1:0] cxa_q, cya_q, cxb_q, cyb_q;
	logic [NODE_W:0]     nb_rd_q;
	logic                blk_rd_q;
	logic [SCORE_W-1:0]  cost_rd_q, est_rd_q;
	logic [NODE_W-1:0]   par_rd_q, pb_rd_q;

	logic                accept, bad_load, bad_find, load_ok, clearing;
	logic                st_emit;
	logic [2:0]          st_code;
	logic [SCORE_W-1:0]  t_new, f_new;
	logic                better;
	logic                dist_done;
	logic [DIST_W-1:0]   dist_val;
	heap_req_t           heap_req;
	heap_rsp_t           heap_rsp;

	logic                coord_we, nb_we, blk_we, cost_we, est_we, par_we, pb_we;
	logic [NODE_W-1:0]   coord_wa, blk_wa, cost_wa, cost_ra;
	logic [NB_AW-1:0]    nb_wa;
	logic [NODE_W:0]     nb_wd;
	logic [PATH_AW-1:0]  pb_ra;

	// Node count in use, held to the range 1..NODES.
	assign cnt = (node_count_q == '0) ? CNT_W'(1) :
		((node_count_q > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_q);

	assign clearing  = (state_q == ST_CLR);
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	assign bad_load = ({1'b0, node} >= cnt) ||
		((mode == MODE_NBR) && neighbour_present && ({1'b0, neighbour} >= cnt));
	assign bad_find = ({1'b0, start_node} >= cnt) || ({1'b0, goal_node} >= cnt);
	assign load_ok  = accept && (mode != MODE_FIND) && !bad_load;

	assign t_new  = sat_add(cost_n_q, SCORE_W'(d_q));
	assign f_new  = sat_add(t_q, SCORE_W'(d_q));
	assign better = !cvalid_q[m_q] || (t_new < costm_q);

	// A single status item ends the request: load acknowledge, bad index, no path,
	// heap overflow or a path longer than the buffer.
	always_comb begin
		st_emit = 1'b0;
		st_code = STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept && ((mode != MODE_FIND) || bad_find)) begin
					st_emit = 1'b1;
					st_code = ((mode == MODE_FIND) ? bad_find : bad_load) ?
						STATUS_BAD_INDEX : STATUS_OK;
				end
			end
			ST_PUSHW: begin
				st_emit = heap_rsp.done && heap_rsp.full;
				st_code = STATUS_OVERFLOW;
			end
			ST_LOOP: begin
				st_emit = heap_rsp.empty;
				st_code = STATUS_NO_PATH;
			end
			ST_PATH: begin
				st_emit = (len_q == PATH_LW'(MAX_PATH));
				st_code = STATUS_TOO_LONG;
			end
			default: begin
				st_emit = 1'b0;
				st_code = STATUS_OK;
			end
		endcase
	end

	// Store write and read ports.
	assign coord_we = clearing || (load_ok && (mode == MODE_COORD));
	assign coord_wa = clearing ? clr_q[NODE_W-1:0] : node;
	assign nb_we    = clearing || (load_ok && (mode == MODE_NBR));
	assign nb_wa    = clearing ? clr_q : {node, slot};
	assign nb_wd    = (clearing || !neighbour_present) ? '0 : {1'b1, neighbour};
	assign blk_we   = clearing || (load_ok && (mode == MODE_BLOCK));
	assign blk_wa   = clearing ? clr_q[NODE_W-1:0] : node;
	assign cost_we  = (state_q == ST_FIND) || ((state_q == ST_T) && better);
	assign cost_wa  = (state_q == ST_FIND) ? start_q : m_q;
	assign cost_ra  = (state_q == ST_NB) ? nb_rd_q[NODE_W-1:0] : n_q;
	assign est_we   = (state_q == ST_H);
	assign par_we   = (state_q == ST_T) && better;
	assign pb_we    = (state_q == ST_PATH) && (len_q != PATH_LW'(MAX_PATH));
	assign pb_ra    = len_q[PATH_AW-1:0] - PATH_AW'(1) - k_q[PATH_AW-1:0];

	always_ff @(posedge clk) begin
		if (coord_we) begin
			cx_mem[coord_wa] <= clearing ? '0 : pos_x;
			cy_mem[coord_wa] <= clearing ? '0 : pos_y;
		end
		cxa_q <= cx_mem[dist_a_q];
		cya_q <= cy_mem[dist_a_q];
		cxb_q <= cx_mem[dist_b_q];
		cyb_q <= cy_mem[dist_b_q];
	end

	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[nb_wa] <= nb_wd;
		end
		nb_rd_q <= nb_mem[{n_q, slot_q}];
	end

	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_wa] <= clearing ? 1'b0 : blocked_flag;
		end
		blk_rd_q <= blk_mem[nb_rd_q[NODE_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[cost_wa] <= (state_q == ST_FIND) ? '0 : t_new;
		end
		cost_rd_q <= cost_mem[cost_ra];
	end

	always_ff @(posedge clk) begin
		if (est_we) begin
			est_mem[m_q] <= f_new;
		end
		est_rd_q <= est_mem[n_q];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[m_q] <= n_q;
		end
		par_rd_q <= par_mem[c_q];
	end

	always_ff @(posedge clk) begin
		if (pb_we) begin
			pb_mem[len_q[PATH_AW-1:0]] <= c_q;
		end
		pb_rd_q <= pb_mem[pb_ra];
	end

	astar_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DGO),
		.ax       (cxa_q),
		.ay       (cya_q),
		.bx       (cxb_q),
		.by       (cyb_q),
		.done     (dist_done),
		.step_len (dist_val)
	);

	assign heap_req.push  = (state_q == ST_H);
	assign heap_req.pop   = (state_q == ST_LOOP) && !heap_rsp.empty;
	assign heap_req.clear = (state_q == ST_FIND);
	assign heap_req.key   = {f_new, m_q};

	astar_heap u_heap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (heap_req),
		.rsp    (heap_rsp)
	);

	// Search sequencer. A distance is requested by loading both node indices and a
	// return state, then stepping through the read, start and wait states.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			ret_q        <= ST_IDLE;
			clr_q        <= '0;
			node_count_q <= CNT_W'(NODES);
			start_q      <= '0;
			goal_q       <= '0;
			n_q          <= '0;
			m_q          <= '0;
			c_q          <= '0;
			dist_a_q     <= '0;
			dist_b_q     <= '0;
			slot_q       <= '0;
			cost_n_q     <= '0;
			costm_q      <= '0;
			t_q          <= '0;
			cost_goal_q  <= '0;
			key_f_q      <= '0;
			d_q          <= '0;
			len_q        <= '0;
			k_q          <= '0;
			more_q       <= 1'b0;
			cvalid_q     <= '0;
			pvalid_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (st_emit) begin
				out_valid_q <= 1'b1;
				more_q      <= 1'b0;
				state_q     <= ST_OWAIT;
			end else begin
				case (state_q)
					ST_CLR: begin
						clr_q <= clr_q + NB_AW'(1);
						if (clr_q == '1) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							start_q <= start_node;
							goal_q  <= goal_node;
							state_q <= ST_FIND;
						end
					end
					ST_FIND: begin
						// Only the start node carries a known cost when a search begins.
						cvalid_q <= {{(NODES-1){1'b0}}, 1'b1} << start_q;
						pvalid_q <= '0;
						m_q      <= start_q;
						t_q      <= '0;
						dist_a_q <= start_q;
						dist_b_q <= goal_q;
						ret_q    <= ST_H;
						slot_q   <= SLOT_W'(MAX_DEGREE - 1);
						state_q  <= ST_DRD;
					end
					ST_DRD:   state_q <= ST_DGO;
					ST_DGO:   state_q <= ST_DWAIT;
					ST_DWAIT: begin
						if (dist_done) begin
							d_q     <= dist_val;
							state_q <= ret_q;
						end
					end
					ST_H: state_q <= ST_PUSHW;
					ST_PUSHW: begin
						if (heap_rsp.done) begin
							state_q <= ST_NEXT;
						end
					end
					ST_NEXT: begin
						if (slot_q == SLOT_W'(MAX_DEGREE - 1)) begin
							state_q <= ST_LOOP;
						end else begin
							slot_q  <= slot_q + SLOT_W'(1);
							state_q <= ST_NBRD;
						end
					end
					ST_LOOP: state_q <= ST_POPW;
					ST_POPW: begin
						if (heap_rsp.done) begin
							n_q     <= heap_rsp.top[NODE_W-1:0];
							key_f_q <= heap_rsp.top[KEY_W-1:NODE_W];
							state_q <= ST_EST;
						end
					end
					ST_EST: state_q <= ST_CHK;
					ST_CHK: begin
						if (key_f_q != est_rd_q) begin
							// Stale entry left behind by a later improvement.
							state_q <= ST_LOOP;
						end else if (n_q == goal_q) begin
							cost_goal_q <= cost_rd_q;
							c_q         <= goal_q;
							len_q       <= '0;
							state_q     <= ST_PATH;
						end else begin
							cost_n_q <= cost_rd_q;
							slot_q   <= '0;
							state_q  <= ST_NBRD;
						end
					end
					ST_NBRD: state_q <= ST_NB;
					ST_NB: begin
						if (nb_rd_q[NODE_W] && ({1'b0, nb_rd_q[NODE_W-1:0]} < cnt)) begin
							m_q     <= nb_rd_q[NODE_W-1:0];
							state_q <= ST_BLK;
						end else begin
							state_q <= ST_NEXT;
						end
					end
					ST_BLK: begin
						if (blk_rd_q) begin
							state_q <= ST_NEXT;
						end else begin
							costm_q  <= cost_rd_q;
							dist_a_q <= n_q;
							dist_b_q <= m_q;
							ret_q    <= ST_T;
							state_q  <= ST_DRD;
						end
					end
					ST_T: begin
						if (better) begin
							cvalid_q[m_q] <= 1'b1;
							pvalid_q[m_q] <= 1'b1;
							t_q           <= t_new;
							dist_a_q      <= m_q;
							dist_b_q      <= goal_q;
							ret_q         <= ST_H;
							state_q       <= ST_DRD;
						end else begin
							state_q <= ST_NEXT;
						end
					end
					ST_PATH: begin
						len_q <= len_q + PATH_LW'(1);
						if (pvalid_q[c_q]) begin
							state_q <= ST_PAR;
						end else begin
							k_q     <= '0;
							state_q <= ST_ORD;
						end
					end
					ST_PAR: begin
						c_q     <= par_rd_q;
						state_q <= ST_PATH;
					end
					ST_ORD: state_q <= ST_OUT;
					ST_OUT: begin
						out_valid_q <= 1'b1;
						k_q         <= k_q + PATH_LW'(1);
						more_q      <= (k_q + PATH_LW'(1)) != len_q;
						state_q     <= ST_OWAIT;
					end
					ST_OWAIT: begin
						if (!out_valid_q) begin
							state_q <= more_q ? ST_ORD : ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (st_emit) begin
			path_node_q <= '0;
			last_q      <= 1'b1;
			status_q    <= st_code;
			path_cost_q <= '0;
		end else if (state_q == ST_OUT) begin
			path_node_q <= pb_rd_q;
			last_q      <= (k_q + PATH_LW'(1)) == len_q;
			status_q    <= STATUS_OK;
			path_cost_q <= cost_goal_q;
		end
	end

	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign last      = last_q;
	assign status    = status_q;
	assign path_cost = path_cost_q;

	a_out_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == ST_OWAIT))
		else $error("result held outside the wait state");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != STATUS_OK)) |-> last_q)
		else $error("status item not marked last");

	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid_q)
		else $error("request taken while a result is pending");

	a_emit_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		st_emit |-> !out_valid_q)
		else $error("status written over a pending result");

endmodule

>>> sv/astar_dist.sv
// Euclidean distance unit: one shared squarer and a bit-pair integer square root.
`timescale 1ns / 1ps

module astar_dist import astar_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] ax,
	input  logic signed [COORD_W-1:0] ay,
	input  logic signed [COORD_W-1:0] bx,
	input  logic signed [COORD_W-1:0] by,
	output logic                      done,
	output logic [DIST_W-1:0]         step_len
);

	localparam logic [2:0] D_IDLE = 3'd0;
	localparam logic [2:0] D_MX   = 3'd1;
	localparam logic [2:0] D_MY   = 3'd2;
	localparam logic [2:0] D_ADD  = 3'd3;
	localparam logic [2:0] D_ROOT = 3'd4;
	localparam logic [4:0] ROOT_STEPS = 5'(SQ_W / 2);

	logic [2:0]               state_q;
	logic signed [COORD_W:0]  dx_q, dy_q;
	logic signed [COORD_W:0]  mul_op;
	logic signed [SQ_W-1:0]   sq;
	logic [SQ_W-1:0]          prod_q, acc_q, v_q, r_q, bit_q;
	logic [SQ_W:0]            rb;
	logic [4:0]               iter_q;
	logic                     done_q;

	// The single multiplier squares dx, then dy, in consecutive cycles.
	assign mul_op = (state_q == D_MX) ? dx_q : dy_q;
	assign sq     = mul_op * mul_op;
	assign rb     = {1'b0, r_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			iter_q  <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			v_q     <= '0;
			r_q     <= '0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						dx_q    <= {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
						dy_q    <= {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
						state_q <= D_MX;
					end
				end
				D_MX: begin
					prod_q  <= $unsigned(sq);
					state_q <= D_MY;
				end
				D_MY: begin
					acc_q   <= prod_q;
					prod_q  <= $unsigned(sq);
					state_q <= D_ADD;
				end
				D_ADD: begin
					v_q     <= acc_q + prod_q;
					r_q     <= '0;
					bit_q   <= SQ_W'(1) << (SQ_W - 2);
					iter_q  <= ROOT_STEPS;
					state_q <= D_ROOT;
				end
				D_ROOT: begin
					if ({1'b0, v_q} >= rb) begin
						v_q <= v_q - rb[SQ_W-1:0];
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q  <= bit_q >> 2;
					iter_q <= iter_q - 5'd1;
					if (iter_q == 5'd1) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign step_len = r_q[DIST_W-1:0];

endmodule

>>> sv/astar_heap.sv
// Binary min-heap of (f score, node) keys held in a two-read-port memory.
`timescale 1ns / 1ps

module astar_heap import astar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  heap_req_t req,
	output heap_rsp_t rsp
);

	localparam logic [2:0] H_IDLE  = 3'd0;
	localparam logic [2:0] H_PSTEP = 3'd1;
	localparam logic [2:0] H_PCMP  = 3'd2;
	localparam logic [2:0] H_PKEY  = 3'd3;
	localparam logic [2:0] H_DSTEP = 3'd4;
	localparam logic [2:0] H_DCMP  = 3'd5;

	logic [KEY_W-1:0] heap_mem [OPEN_DEPTH];

	logic [2:0]         st_q, st_d;
	logic [HEAP_CW-1:0] count_q, count_d;
	logic [HEAP_AW-1:0] i_q, i_d, p_q, p_d, p_calc;
	logic [KEY_W-1:0]   key_q, key_d, top_q, top_d;
	logic               done_q, done_d, full_q, full_d;
	logic               we;
	logic [HEAP_AW-1:0] wa, ra, rb;
	logic [KEY_W-1:0]   wd, rd_a_q, rd_b_q, child;
	logic [HEAP_AW+1:0] c_w, c1_w, cnt_x;
	logic               take_b;

	assign p_calc = (i_q - HEAP_AW'(1)) >> 1;
	assign c_w    = {1'b0, i_q, 1'b1};
	assign c1_w   = c_w + (HEAP_AW+2)'(1);
	assign cnt_x  = {1'b0, count_q};
	assign take_b = (c1_w < cnt_x) && (rd_b_q < rd_a_q);
	assign child  = take_b ? rd_b_q : rd_a_q;

	always_comb begin
		st_d    = st_q;
		count_d = count_q;
		i_d     = i_q;
		p_d     = p_q;
		key_d   = key_q;
		top_d   = top_q;
		done_d  = 1'b0;
		full_d  = full_q;
		we      = 1'b0;
		wa      = i_q;
		wd      = key_q;
		ra      = '0;
		rb      = '0;
		case (st_q)
			H_IDLE: begin
				if (req.clear) begin
					count_d = '0;
				end else if (req.push) begin
					if (count_q == HEAP_CW'(OPEN_DEPTH)) begin
						done_d = 1'b1;
						full_d = 1'b1;
					end else begin
						full_d  = 1'b0;
						i_d     = count_q[HEAP_AW-1:0];
						count_d = count_q + HEAP_CW'(1);
						key_d   = req.key;
						st_d    = H_PSTEP;
					end
				end else if (req.pop) begin
					ra      = '0;
					rb      = HEAP_AW'(count_q - HEAP_CW'(1));
					count_d = count_q - HEAP_CW'(1);
					full_d  = 1'b0;
					st_d    = H_PKEY;
				end
			end
			H_PSTEP: begin
				if (i_q == '0) begin
					we     = 1'b1;
					done_d = 1'b1;
					st_d   = H_IDLE;
				end else begin
					ra   = p_calc;
					p_d  = p_calc;
					st_d = H_PCMP;
				end
			end
			H_PCMP: begin
				we = 1'b1;
				if (rd_a_q <= key_q) begin
					done_d = 1'b1;
					st_d   = H_IDLE;
				end else begin
					wd   = rd_a_q;
					i_d  = p_q;
					st_d = H_PSTEP;
				end
			end
			H_PKEY: begin
				top_d = rd_a_q;
				key_d = rd_b_q;
				i_d   = '0;
				st_d  = H_DSTEP;
			end
			H_DSTEP: begin
				if (c_w >= cnt_x) begin
					we     = (count_q != '0);
					done_d = 1'b1;
					st_d   = H_IDLE;
				end else begin
					ra   = c_w[HEAP_AW-1:0];
					rb   = c1_w[HEAP_AW-1:0];
					st_d = H_DCMP;
				end
			end
			H_DCMP: begin
				we = 1'b1;
				if (key_q <= child) begin
					done_d = 1'b1;
					st_d   = H_IDLE;
				end else begin
					wd   = child;
					i_d  = take_b ? c1_w[HEAP_AW-1:0] : c_w[HEAP_AW-1:0];
					st_d = H_DSTEP;
				end
			end
			default: st_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= H_IDLE;
			count_q <= '0;
			i_q     <= '0;
			p_q     <= '0;
			key_q   <= '0;
			top_q   <= '0;
			done_q  <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
			i_q     <= i_d;
			p_q     <= p_d;
			key_q   <= key_d;
			top_q   <= top_d;
			done_q  <= done_d;
			full_q  <= full_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[wa] <= wd;
		end
		rd_a_q <= heap_mem[ra];
		rd_b_q <= heap_mem[rb];
	end

	assign rsp.done  = done_q;
	assign rsp.full  = full_q;
	assign rsp.empty = (count_q == '0);
	assign rsp.top   = top_q;

endmodule
